@@ design/bba_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// bba_pkg
// Shared types, sizes and codes for the bitmap block allocator.
// ============================================================================
package bba_pkg;

    localparam int NUM_BLOCKS = 4096;
    localparam int MAP_BYTES  = (NUM_BLOCKS + 7) / 8;
    localparam int ADDR_W     = $clog2(MAP_BYTES);
    localparam int FILL_W     = $clog2(MAP_BYTES + 1);
    localparam int BLK_W      = 12;
    localparam int CNT_W      = 13;

    localparam logic [7:0] FULL_BYTE = 8'hFF;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_ROOT  = 2'd2;
    localparam t_status ST_RANGE = 2'd3;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // bitmap write request
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_wr_req;

    // index of the lowest zero bit; only meaningful when b != FULL_BYTE
    function automatic logic [2:0] lowest_clear(input logic [7:0] b);
        logic [2:0] pos;
        pos = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (!b[i]) begin
                pos = 3'(i);
            end
        end
        return pos;
    endfunction

endpackage

@@ design/bitmap_block_allocator_top.sv @@
`timescale 1ns / 1ps
// Allocate scans the bitmap from byte 0, reading one byte per cycle, and stops at
//   the first byte with a clear bit, at the limit or at the last byte; free reads the
//   block's byte and writes it back with the bit cleared; refused and out-of-range
//   frees go straight to the result. Only one request is in flight at a time; the next
//   is taken once the result sits in the output register. Reset (sync, active low)
//   empties the bitmap at once through a fill count, sets block_count to 4096 and drops all valids.
// ============================================================================
// bitmap_block_allocator_top
// Bitmap free-block allocator: allocate takes the lowest clear bit below the
// block count, free clears a block's bit unless it is block 0 or not below the count.
// ============================================================================
module bitmap_block_allocator_top
    import bba_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    // config write: block_count
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CNT_W-1:0] i_cfg_data,
    // request stream
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [15:0]      s_axis_tdata,   // [11:0] block_index, [15:12] zero
    input  logic             s_axis_tuser,   // [0] req_type
    // result stream
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [11:0] granted_block, [15:12] zero
    output logic [1:0]       m_axis_tuser    // [1:0] status
);

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_SCAN    = 5'b00010,
        S_FREE_RD = 5'b00100,
        S_FREE_WR = 5'b01000,
        S_DONE    = 5'b10000
    } t_state;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_limit;        // min(block_count, NUM_BLOCKS)
    logic [ADDR_W-1:0] r_ptr;          // byte address being read
    logic [ADDR_W-1:0] r_chk_ptr;      // byte address whose data is on the read port
    logic              r_chk_vld;
    logic [BLK_W-1:0]  r_idx;          // block of a pending free
    logic [BLK_W-1:0]  r_res_blk;
    t_status           r_res_st;
    logic              r_out_valid;
    logic [BLK_W-1:0]  r_out_blk;
    t_status           r_out_st;

    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;
    t_wr_req           wr;
    logic [2:0]        clr_bit;
    logic [BLK_W-1:0]  cand_blk;
    logic              past_limit;
    logic              cand_ok;
    logic              out_free;
    logic              in_acc;
    logic [BLK_W-1:0]  in_idx;

    // ------------------------------------------------------------------
    // Config: always ready, count clamped when written
    // ------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= CNT_W'(NUM_BLOCKS);
        end else if (i_cfg_valid) begin
            r_limit <= (i_cfg_data > CNT_W'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS) : i_cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // Bitmap RAM
    // ------------------------------------------------------------------
    assign rd_addr = (r_state == S_SCAN) ? r_ptr : r_idx[BLK_W-1:3];

    bba_bitmap u_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr      (wr)
    );

    // ------------------------------------------------------------------
    // Scan evaluation on the byte returned by the RAM
    // ------------------------------------------------------------------
    assign clr_bit    = lowest_clear(rd_data);
    assign cand_blk   = {r_chk_ptr, clr_bit};
    // whole byte at or above the limit: nothing more can be granted
    assign past_limit = {1'b0, r_chk_ptr, 3'b000} >= r_limit;
    assign cand_ok    = (rd_data != FULL_BYTE) && ({1'b0, cand_blk} < r_limit);

    always_comb begin
        wr = '0;
        if (r_state == S_SCAN && r_chk_vld && !past_limit && cand_ok) begin
            wr.en   = 1'b1;
            wr.addr = r_chk_ptr;
            wr.data = rd_data | (8'h01 << clr_bit);
        end else if (r_state == S_FREE_WR) begin
            wr.en   = 1'b1;
            wr.addr = r_idx[BLK_W-1:3];
            wr.data = rd_data & ~(8'h01 << r_idx[2:0]);
        end
    end

    // ------------------------------------------------------------------
    // Control
    // ------------------------------------------------------------------
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign in_idx        = s_axis_tdata[BLK_W-1:0];
    assign out_free      = !r_out_valid || m_axis_tready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (s_axis_tuser == REQ_ALLOC) begin
                        n_state = S_SCAN;
                    end else if (in_idx == '0 || {1'b0, in_idx} >= r_limit) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_FREE_RD;
                    end
                end
            end
            S_SCAN: begin
                if (r_chk_vld && (past_limit || rd_data != FULL_BYTE ||
                                  r_chk_ptr == ADDR_W'(MAP_BYTES - 1))) begin
                    n_state = S_DONE;
                end
            end
            S_FREE_RD: n_state = S_FREE_WR;
            S_FREE_WR: n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_chk_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_chk_vld <= (r_state == S_SCAN) && (n_state == S_SCAN);
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_chk_ptr <= r_ptr;
        case (r_state)
            S_IDLE: begin
                r_ptr <= '0;
                r_idx <= in_idx;
                if (in_idx == '0) begin
                    r_res_blk <= '0;
                    r_res_st  <= ST_ROOT;
                end else begin
                    r_res_blk <= in_idx;
                    r_res_st  <= ST_RANGE;
                end
            end
            S_SCAN: begin
                r_ptr <= r_ptr + 1'b1;
                if (!past_limit && cand_ok) begin
                    r_res_blk <= cand_blk;
                    r_res_st  <= ST_OK;
                end else begin
                    r_res_blk <= '0;
                    r_res_st  <= ST_FULL;
                end
            end
            S_FREE_WR: begin
                r_res_blk <= r_idx;
                r_res_st  <= ST_OK;
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_out_blk <= r_res_blk;
            r_out_st  <= r_res_st;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(16-BLK_W){1'b0}}, r_out_blk};
    assign m_axis_tuser  = r_out_st;

`ifndef SYNTHESIS
    // a taken request always takes the FSM out of idle in the next cycle
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_state != S_IDLE)
        else $error("request taken but FSM stayed idle");

    // bitmap is only written while scanning or finishing a free
    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr.en |-> (r_state == S_SCAN || r_state == S_FREE_WR))
        else $error("bitmap write outside scan/free");

    // a full report never carries a block number
    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == ST_FULL) |-> m_axis_tdata == '0)
        else $error("full status with nonzero block");

    // a grant from the scan is always below the configured limit
    a_grant_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr.en && r_state == S_SCAN |-> {1'b0, cand_blk} < r_limit)
        else $error("granted block outside limit");
`endif

endmodule

@@ design/bba_bitmap.sv @@
`timescale 1ns / 1ps
// ============================================================================
// bba_bitmap
// Used-block bitmap RAM, one byte per entry, with a fill count that makes
// never-written bytes read as zero.
// ============================================================================
module bba_bitmap
    import bba_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [7:0]        o_rd_data,
    input  t_wr_req           i_wr
);

    logic [7:0]        mem [MAP_BYTES];
    logic [7:0]        r_rd_data;
    logic              r_rd_hit;
    logic [FILL_W-1:0] r_fill;
    logic              wr_ok;

    // bytes at or above the fill count were never written: they are zero
    assign wr_ok = i_wr.en && ({{(FILL_W-ADDR_W){1'b0}}, i_wr.addr} <= r_fill);

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_data <= mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_rd_hit <= 1'b0;
        end else begin
            r_rd_hit <= ({{(FILL_W-ADDR_W){1'b0}}, i_rd_addr} < r_fill);
            if (wr_ok && ({{(FILL_W-ADDR_W){1'b0}}, i_wr.addr} == r_fill)) begin
                r_fill <= r_fill + 1'b1;
            end
        end
    end

    assign o_rd_data = r_rd_hit ? r_rd_data : 8'h00;

endmodule
